// ----- sv/stlp_pkg.sv -----
// ----------------------------------------------------------------------------
// stlp_pkg: shared types and constants of the sensor text line parser
// Holds character codes, field phases, the line record that travels from the
// parser front end to the result stage, and the output packing widths.
// ----------------------------------------------------------------------------
`default_nettype none

package stlp_pkg;

  localparam int MAX_LINE_DEFAULT = 96;
  localparam int QUEUE_DEPTH      = 4;

  localparam int VAL_W      = 16;
  localparam int NUM_VALS   = 6;
  localparam int COUNT_W    = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_BITS   = 1 + NUM_VALS * VAL_W + 2 * COUNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Field phases of the integer being read.
  localparam logic [1:0] PHASE_BEFORE = 2'd0;
  localparam logic [1:0] PHASE_SIGN   = 2'd1;
  localparam logic [1:0] PHASE_DIGITS = 2'd2;

  localparam logic [2:0] PREFIX_LEN      = 3'd4;
  localparam logic [2:0] LAST_FIELD      = 3'd6;
  localparam logic [2:0] ALL_FIELDS_DONE = 3'd7;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_U     = 8'h55;

  localparam logic [15:0] MAG_LIMIT = 16'd32768;
  localparam logic [15:0] POS_MAX   = 16'h7FFF;
  localparam logic [15:0] NEG_MIN   = 16'h8000;

  // One finished line: pass flag and the six values, accel_x in element 0.
  typedef struct packed {
    logic                           ok;
    logic [NUM_VALS-1:0][VAL_W-1:0] vals;
  } stlp_rec_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      2'd0: ch = CHAR_I;
      2'd1: ch = CHAR_M;
      2'd2: ch = CHAR_U;
      2'd3: ch = CHAR_COMMA;
      default: ch = CHAR_COMMA;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- sv/stlp_front.sv -----
// ----------------------------------------------------------------------------
// stlp_front: byte classifier and line parser
// Takes one byte per cycle while the line queue has room, tracks the prefix,
// field and digit state of the line; a non-empty line's end queues its record.
// ----------------------------------------------------------------------------
`default_nettype none

module stlp_front #(
  parameter int MAX_LINE = stlp_pkg::MAX_LINE_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [stlp_pkg::IN_DATA_W-1:0] in_byte,
  input  wire logic                          q_full,
  output logic                               q_push,
  output stlp_pkg::stlp_rec_t                q_rec
);
  import stlp_pkg::*;

  localparam int LEN_W = $clog2(MAX_LINE);

  logic [2:0]       prefix_pos, prefix_pos_next;
  logic [2:0]       field_num, field_num_next;
  logic [1:0]       phase, phase_next;
  logic             sign_neg, sign_neg_next;
  logic [15:0]      mag, mag_next;
  logic [LEN_W-1:0] len, len_next;
  logic             failed, failed_next;
  logic             ended, ended_next;
  logic [VAL_W-1:0] vals [NUM_VALS];
  logic             val_we;
  logic [2:0]       val_idx;

  logic             accept, is_eol, is_blank, is_digit, is_sign;
  logic [VAL_W-1:0] fin_bits;
  logic [19:0]      mag_prod;
  logic [15:0]      mag_acc;
  logic             line_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_eol   = (in_byte == CHAR_LF) || (in_byte == CHAR_CR);
  assign is_blank = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB) ||
                    (in_byte == CHAR_VT) || (in_byte == CHAR_FF);
  assign is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign is_sign  = (in_byte == CHAR_PLUS) || (in_byte == CHAR_MINUS);

  // Close of the current integer, saturated to signed 16 bits.
  always_comb begin
    if (sign_neg) begin
      fin_bits = (mag >= MAG_LIMIT) ? NEG_MIN : 16'(16'd0 - mag);
    end else begin
      fin_bits = (mag > POS_MAX) ? POS_MAX : mag;
    end
  end

  // Multiply by ten as shift and add, then add the digit and saturate.
  always_comb begin
    mag_prod = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} +
               {12'd0, 8'(in_byte - CHAR_ZERO)};
    mag_acc  = (mag_prod > 20'(MAG_LIMIT)) ? MAG_LIMIT : mag_prod[15:0];
  end

  assign line_ok = !failed && (prefix_pos >= PREFIX_LEN) &&
                   ((field_num >= ALL_FIELDS_DONE) ||
                    ((field_num == LAST_FIELD) && (phase == PHASE_DIGITS)));

  always_comb begin
    prefix_pos_next = prefix_pos;
    field_num_next  = field_num;
    phase_next      = phase;
    sign_neg_next   = sign_neg;
    mag_next        = mag;
    len_next        = len;
    failed_next     = failed;
    ended_next      = ended;
    val_we          = 1'b0;
    val_idx         = 3'(field_num - 3'd1);
    q_push          = 1'b0;
    q_rec.ok        = line_ok;
    for (int k = 0; k < NUM_VALS; k++) begin
      q_rec.vals[k] = line_ok ? vals[k] : '0;
    end
    if (line_ok && field_num == LAST_FIELD) begin
      q_rec.vals[NUM_VALS-1] = fin_bits;
    end

    if (accept) begin
      if (is_eol) begin
        if (len != '0) begin
          q_push          = 1'b1;
          prefix_pos_next = '0;
          field_num_next  = '0;
          phase_next      = PHASE_BEFORE;
          sign_neg_next   = 1'b0;
          mag_next        = '0;
          len_next        = '0;
          failed_next     = 1'b0;
          ended_next      = 1'b0;
        end
      end else if (len < LEN_W'(MAX_LINE - 1)) begin
        len_next = len + LEN_W'(1);
        if (failed || ended) begin
          // Rest of the line is not parsed.
        end else if (in_byte == CHAR_NUL) begin
          ended_next = 1'b1;
        end else if (prefix_pos < PREFIX_LEN) begin
          if (in_byte == prefix_char(prefix_pos[1:0])) begin
            prefix_pos_next = prefix_pos + 3'd1;
          end else begin
            failed_next = 1'b1;
          end
        end else if (field_num >= ALL_FIELDS_DONE) begin
          // Trailing text after the last integer is ignored.
        end else if (phase == PHASE_BEFORE && is_blank) begin
          // Leading blank.
        end else if (phase == PHASE_BEFORE && is_sign) begin
          sign_neg_next = (in_byte == CHAR_MINUS);
          phase_next    = PHASE_SIGN;
        end else if (phase == PHASE_BEFORE || phase == PHASE_SIGN) begin
          if (!is_digit) begin
            failed_next = 1'b1;
          end else begin
            phase_next = PHASE_DIGITS;
            mag_next   = mag_acc;
          end
        end else if (!is_digit) begin
          val_we = (field_num >= 3'd1) && (field_num <= LAST_FIELD);
          if (field_num >= LAST_FIELD) begin
            field_num_next = ALL_FIELDS_DONE;
          end else if (in_byte == CHAR_COMMA) begin
            field_num_next = field_num + 3'd1;
            phase_next     = PHASE_BEFORE;
            sign_neg_next  = 1'b0;
            mag_next       = '0;
          end else begin
            failed_next = 1'b1;
          end
        end else begin
          mag_next = mag_acc;
        end
      end else begin
        // Overlong line: drop it and start over.
        prefix_pos_next = '0;
        field_num_next  = '0;
        phase_next      = PHASE_BEFORE;
        sign_neg_next   = 1'b0;
        mag_next        = '0;
        len_next        = '0;
        failed_next     = 1'b0;
        ended_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pos <= '0;
      field_num  <= '0;
      phase      <= PHASE_BEFORE;
      sign_neg   <= 1'b0;
      mag        <= '0;
      len        <= '0;
      failed     <= 1'b0;
      ended      <= 1'b0;
      for (int k = 0; k < NUM_VALS; k++) begin
        vals[k] <= '0;
      end
    end else begin
      prefix_pos <= prefix_pos_next;
      field_num  <= field_num_next;
      phase      <= phase_next;
      sign_neg   <= sign_neg_next;
      mag        <= mag_next;
      len        <= len_next;
      failed     <= failed_next;
      ended      <= ended_next;
      for (int k = 0; k < NUM_VALS; k++) begin
        if (val_we && val_idx == 3'(k)) begin
          vals[k] <= fin_bits;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/stlp_queue.sv -----
// ----------------------------------------------------------------------------
// stlp_queue: short queue of finished line records
// Decouples the byte parser from the result stage so each can stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module stlp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire stlp_pkg::stlp_rec_t  push_rec,
  output logic                      full,
  output logic                      pop_valid,
  input  wire logic                 pop,
  output stlp_pkg::stlp_rec_t       pop_rec
);
  import stlp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  stlp_rec_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_rec   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/stlp_back.sv -----
// ----------------------------------------------------------------------------
// stlp_back: result stage
// Takes line records from the queue, updates the good and bad line counts
// and holds the packed result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stlp_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_valid,
  input  wire stlp_pkg::stlp_rec_t            q_rec,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [stlp_pkg::OUT_DATA_W-1:0]     out_data
);
  import stlp_pkg::*;

  logic [COUNT_W-1:0] good_count, bad_count;
  logic [COUNT_W-1:0] good_count_next, bad_count_next;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    good_count_next = good_count + COUNT_W'(q_rec.ok);
    bad_count_next  = bad_count + COUNT_W'(!q_rec.ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      good_count <= '0;
      bad_count  <= '0;
    end else begin
      if (q_pop) begin
        out_valid  <= 1'b1;
        good_count <= good_count_next;
        bad_count  <= bad_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= OUT_DATA_W'({bad_count_next, good_count_next, q_rec.vals, q_rec.ok});
    end
  end

endmodule

`default_nettype wire

// ----- sv/sensor_text_line_parser.sv -----
// ----------------------------------------------------------------------------
// sensor_text_line_parser: IMU text line parser
// Parses "IMU," lines of seven integers from a byte stream into one result
// per non-empty line with a pass flag, six saturated values and counts.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle on the slave stream. Bytes are
// parsed as they arrive; the CR or LF that ends a non-empty line pushes the
// line's record into a four-entry queue, from which it moves into the output
// register that drives the master stream. The slave side stalls only
// when the queue holds four results that the master side has not yet taken,
// so the sustained rate is one byte per cycle while results are drained.
`default_nettype none

module sensor_text_line_parser #(
  parameter int MAX_LINE = stlp_pkg::MAX_LINE_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [stlp_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] line_ok, [16:1] accel_x, [32:17] accel_y, [48:33] accel_z,
  // [64:49] rate_x, [80:65] rate_y, [96:81] rate_z, [128:97] good_lines,
  // [160:129] bad_lines, upper bits zero
  output logic [stlp_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import stlp_pkg::*;

  stlp_rec_t push_rec, pop_rec;
  logic      q_full, q_push, q_valid, q_pop;

  stlp_front #(
    .MAX_LINE(MAX_LINE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  stlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_rec   (pop_rec)
  );

  stlp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_rec     (pop_rec),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sensor text line parser
// Streams text bytes into the parser and checks every line result against a
// behavioral parser kept in the bench. Directed lines cover the special
// cases; random lines follow: mostly well-formed IMU lines with random
// content, and some noise, broken and overlong lines. Idling on both
// streams changes by phase, and the result side holds off once for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import stlp_pkg::*;

  localparam int VALS_LSB     = 1;
  localparam int GOOD_LSB     = VALS_LSB + NUM_VALS * VAL_W;
  localparam int BAD_LSB      = GOOD_LSB + COUNT_W;
  localparam int LEN_CAP      = MAX_LINE_DEFAULT - 1;
  localparam int PHASE_CHARS  = 350;
  localparam int HOLD_CYCLES  = 1000;
  localparam int HOLD_AFTER   = 20;
  // Longest quiet stretch in a correct run is the long hold-off.
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [3:0][7:0] IMU_TAG = {CHAR_COMMA, CHAR_U, CHAR_M, CHAR_I};
  localparam logic [3:0][7:0] BLANKS  = {CHAR_FF, CHAR_VT, CHAR_TAB, CHAR_SPACE};

  typedef struct packed {
    logic                           ok;
    logic [NUM_VALS-1:0][VAL_W-1:0] vals;
    logic [COUNT_W-1:0]             good;
    logic [COUNT_W-1:0]             bad;
  } line_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [7:0]   char_feed_q[$];
  logic [7:0]   line_buf[$];
  line_result_t pending_lines[$];
  int unsigned  queued_chars;
  int unsigned  send_gap_pct;
  int unsigned  recv_stall_pct;
  int unsigned  results_seen;
  int unsigned  fail_count;
  int unsigned  quiet_cycles;
  int unsigned  hold_left;
  logic         hold_done;
  logic         byte_taken;

  string val_names [NUM_VALS] = '{"accel_x", "accel_y", "accel_z",
                                  "rate_x", "rate_y", "rate_z"};

  // Behavioral parser state.
  logic [2:0]                     tag_matched;
  logic [2:0]                     fld_idx;
  logic [1:0]                     fld_phase;
  logic                           neg_sign;
  logic [15:0]                    digit_acc;
  logic [NUM_VALS-1:0][VAL_W-1:0] held_vals;
  logic [6:0]                     held_len;
  logic                           line_bad;
  logic                           text_done;
  logic [COUNT_W-1:0]             good_total;
  logic [COUNT_W-1:0]             bad_total;

  sensor_text_line_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic imu_clear_line();
    tag_matched = '0;
    fld_idx     = '0;
    fld_phase   = PHASE_BEFORE;
    neg_sign    = 1'b0;
    digit_acc   = '0;
    held_len    = '0;
    line_bad    = 1'b0;
    text_done   = 1'b0;
  endtask

  // Saturate the current integer and keep it if it is one of the six values.
  task automatic imu_close_field();
    logic [15:0] v;
    if (neg_sign) begin
      v = (digit_acc >= MAG_LIMIT) ? NEG_MIN : (~digit_acc + 16'd1);
    end else begin
      v = (digit_acc > POS_MAX) ? POS_MAX : digit_acc;
    end
    if (fld_idx >= 3'd1 && fld_idx <= LAST_FIELD) held_vals[fld_idx - 3'd1] = v;
  endtask

  task automatic imu_parse_char(input logic [7:0] ch);
    logic [31:0] acc;
    logic        is_dig;
    is_dig = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    if (line_bad || text_done) return;
    if (ch == CHAR_NUL) begin
      text_done = 1'b1;
      return;
    end
    if (tag_matched < PREFIX_LEN) begin
      if (ch == IMU_TAG[tag_matched[1:0]]) tag_matched = tag_matched + 3'd1;
      else line_bad = 1'b1;
      return;
    end
    if (fld_idx >= ALL_FIELDS_DONE) return;
    if (fld_phase == PHASE_BEFORE) begin
      if (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_VT || ch == CHAR_FF) return;
      if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
        neg_sign  = (ch == CHAR_MINUS);
        fld_phase = PHASE_SIGN;
        return;
      end
    end
    if (fld_phase != PHASE_DIGITS) begin
      if (!is_dig) begin
        line_bad = 1'b1;
        return;
      end
      fld_phase = PHASE_DIGITS;
    end else if (!is_dig) begin
      // Any non-digit closes the integer; after the last one the rest is ignored.
      imu_close_field();
      if (fld_idx >= LAST_FIELD) begin
        fld_idx = ALL_FIELDS_DONE;
      end else if (ch == CHAR_COMMA) begin
        fld_idx   = fld_idx + 3'd1;
        fld_phase = PHASE_BEFORE;
        neg_sign  = 1'b0;
        digit_acc = '0;
      end else begin
        line_bad = 1'b1;
      end
      return;
    end
    acc = 32'(digit_acc) * 32'd10 + 32'(ch - CHAR_ZERO);
    digit_acc = (acc > 32'(MAG_LIMIT)) ? MAG_LIMIT : acc[15:0];
  endtask

  task automatic imu_take_byte(input logic [7:0] ch);
    line_result_t r;
    logic         ok;
    if (ch == CHAR_LF || ch == CHAR_CR) begin
      if (held_len != 0) begin
        ok = 1'b0;
        if (!line_bad && tag_matched >= PREFIX_LEN) begin
          if (fld_idx >= ALL_FIELDS_DONE) begin
            ok = 1'b1;
          end else if (fld_idx == LAST_FIELD && fld_phase == PHASE_DIGITS) begin
            imu_close_field();
            ok = 1'b1;
          end
        end
        if (ok) good_total = good_total + 1'b1;
        else bad_total = bad_total + 1'b1;
        r.ok   = ok;
        r.vals = ok ? held_vals : '0;
        r.good = good_total;
        r.bad  = bad_total;
        pending_lines.push_back(r);
        imu_clear_line();
      end
    end else if (held_len < 7'(LEN_CAP)) begin
      held_len = held_len + 7'd1;
      imu_parse_char(ch);
    end else begin
      // The character past the cap is dropped together with the whole line.
      imu_clear_line();
    end
  endtask

  task automatic report_mismatch(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    fail_count++;
  endtask

  task automatic check_line_result(input logic [OUT_DATA_W-1:0] d);
    line_result_t want;
    if (pending_lines.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %h", $time, d);
      fail_count++;
      return;
    end
    want = pending_lines.pop_front();
    if (d[0] !== want.ok) report_mismatch("line_ok", 32'(want.ok), 32'(d[0]));
    for (int k = 0; k < NUM_VALS; k++) begin
      if (d[VALS_LSB + k * VAL_W +: VAL_W] !== want.vals[k])
        report_mismatch(val_names[k], 32'(want.vals[k]),
                        32'(d[VALS_LSB + k * VAL_W +: VAL_W]));
    end
    if (d[GOOD_LSB +: COUNT_W] !== want.good)
      report_mismatch("good_lines", want.good, d[GOOD_LSB +: COUNT_W]);
    if (d[BAD_LSB +: COUNT_W] !== want.bad)
      report_mismatch("bad_lines", want.bad, d[BAD_LSB +: COUNT_W]);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic end_line(input logic [7:0] term);
    line_buf.push_back(term);
    foreach (line_buf[i]) char_feed_q.push_back(line_buf[i]);
    queued_chars += line_buf.size();
    line_buf.delete();
  endtask

  task automatic put_random_number();
    int unsigned r;
    int unsigned ndig;
    r = $urandom_range(99);
    if (r < 50) ndig = $urandom_range(1, 3);
    else if (r < 85) ndig = $urandom_range(4, 5);
    else ndig = $urandom_range(6, 9);
    repeat (ndig) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic add_random_line();
    int unsigned pick;
    int unsigned shape;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 4) begin
      // Crosses the length cap; whatever follows the dropped character
      // starts a fresh line.
      n = $urandom_range(96, 130);
      repeat (n) line_buf.push_back(8'($urandom_range(32, 126)));
    end else if (pick < 20) begin
      n = $urandom_range(1, 24);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
    end else begin
      put_text("IMU,");
      for (int f = 0; f < 7; f++) begin
        if (f != 0) line_buf.push_back(CHAR_COMMA);
        if ($urandom_range(3) == 0) begin
          n = $urandom_range(1, 3);
          repeat (n) line_buf.push_back(BLANKS[2'($urandom_range(3))]);
        end
        case ($urandom_range(3))
          0: line_buf.push_back(CHAR_PLUS);
          1: line_buf.push_back(CHAR_MINUS);
          default: ;
        endcase
        put_random_number();
      end
      shape = $urandom_range(99);
      if (shape >= 85) begin
        line_buf.push_back(CHAR_NUL);
        n = $urandom_range(0, 6);
        repeat (n) line_buf.push_back(8'($urandom_range(255)));
      end else if (shape >= 70) begin
        n = $urandom_range(1, 8);
        repeat (n) line_buf.push_back(8'($urandom_range(32, 126)));
      end
      if (pick < 32) begin
        if ($urandom_range(1) == 0) begin
          line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
        end else begin
          n = $urandom_range(1, line_buf.size() - 1);
          while (line_buf.size() > n) void'(line_buf.pop_back());
        end
      end
    end
    case ($urandom_range(4))
      0, 1: end_line(CHAR_LF);
      2, 3: end_line(CHAR_CR);
      default: begin
        end_line(CHAR_CR);
        end_line(CHAR_LF);
      end
    endcase
  endtask

  task automatic add_random_phase();
    int unsigned start;
    start = queued_chars;
    while (queued_chars - start < PHASE_CHARS) add_random_line();
  endtask

  task automatic wait_drained();
    while (char_feed_q.size() != 0 || s_axis_tvalid || pending_lines.size() != 0)
      @(posedge clk);
  endtask

  // Byte sender.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (char_feed_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        s_axis_tdata  <= char_feed_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off once enough results have come.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Prediction on each byte transfer, checking on each result transfer.
  always @(posedge clk) begin
    if (rst) begin
      byte_taken <= 1'b0;
      imu_clear_line();
      held_vals    = '0;
      good_total   = '0;
      bad_total    = '0;
      quiet_cycles = 0;
    end else begin
      byte_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) imu_take_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        check_line_result(m_axis_tdata);
        results_seen++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    queued_chars   = 0;
    results_seen   = 0;
    fail_count     = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    send_gap_pct   = 20;
    recv_stall_pct = 76;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed lines.
    put_text("IMU,123,1,2,3,4,5,6");
    end_line(CHAR_LF);
    put_text("IMU,4294967295,32767,-32768,32768,-32769,+0,-0");
    end_line(CHAR_CR);
    end_line(CHAR_LF);
    put_text("IMU,");
    line_buf.push_back(CHAR_SPACE);
    line_buf.push_back(CHAR_TAB);
    line_buf.push_back(CHAR_VT);
    line_buf.push_back(CHAR_FF);
    put_text("7, -1,+2,  3,4,5,6;extra,text");
    end_line(CHAR_LF);
    put_text("IMU,1,2,3,4,5,66");
    line_buf.push_back(CHAR_NUL);
    put_text("zz");
    end_line(CHAR_LF);
    put_text("IMU,1,2,3,4,5,6,7,8");
    end_line(CHAR_LF);
    put_text("IMX,1,2,3,4,5,6,7");
    end_line(CHAR_LF);
    put_text("IMU,1,2,3");
    end_line(CHAR_LF);
    put_text("IMU,1,,3,4,5,6,7");
    end_line(CHAR_LF);
    put_text("IMU,1,2,3,4,5,6,-");
    end_line(CHAR_LF);
    put_text("IMU,1,2 ,3,4,5,6,7");
    end_line(CHAR_LF);
    put_text("IMU,+,1,2,3,4,5,6");
    end_line(CHAR_LF);
    line_buf.push_back(CHAR_NUL);
    end_line(CHAR_LF);
    put_text("IMU,99999999999999,1,2,3,4,5,6");
    end_line(CHAR_CR);
    put_text("IMU");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h80);
    end_line(CHAR_LF);
    // A line of exactly the cap, then one character over it.
    put_text("IMU,0,1,2,3,4,5,6");
    repeat (78) line_buf.push_back("x");
    end_line(CHAR_LF);
    put_text("IMU,0,1,2,3,4,5,6");
    repeat (79) line_buf.push_back("x");
    end_line(CHAR_LF);
    repeat (95) line_buf.push_back("A");
    put_text("#IMU,5,-6,7,-8,9,-10,11");
    end_line(CHAR_LF);

    add_random_phase();
    wait_drained();

    send_gap_pct   = 76;
    recv_stall_pct = 20;
    add_random_phase();
    wait_drained();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    add_random_phase();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_lines.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
